// ===== design/bfa_pkg.sv =====
package bfa_pkg;

    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam logic [15:0] RESET_BASE   = 16'd64;
    localparam logic [15:0] RESET_LENGTH = 16'd4032;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic CFG_ARENA_BASE   = 1'b0;
    localparam logic CFG_ARENA_LENGTH = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic [15:0] len;
        logic [15:0] nxt;
    } t_hdr;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_A_STEP,
        S_A_FIN,
        S_A_WRB,
        S_A_RDP,
        S_A_LNK,
        S_F_CHK,
        S_F_MARK,
        S_F_WCHK,
        S_F_STEP,
        S_F_PREV,
        S_F_RDP,
        S_F_LNK,
        S_F_FOL,
        S_F_MRG,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_INIT,
        OP_LOAD,
        OP_RD_CUR,
        OP_A_STEP,
        OP_A_FIN,
        OP_A_WRB,
        OP_RD_BPREV,
        OP_A_LNK,
        OP_F_CHK,
        OP_F_MARK,
        OP_F_STEP,
        OP_F_PREV,
        OP_RD_LPREV,
        OP_F_LNK,
        OP_F_FOL,
        OP_F_MRG,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic clr_last;
        logic walk_end_a;
        logic walk_end_f;
        logic found;
        logic bhead;
        logic lhead;
        logic buf_bad;
        logic mark_bad;
        logic merge_prev;
        logic merge_fol;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/bfa_ram.sv =====
module bfa_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

// ===== design/bfa_ctrl.sv =====
module bfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_cmd,
    input  logic              i_cfg_we,
    input  bfa_pkg::t_dp_stat i_stat,
    output bfa_pkg::t_op      o_op,
    output logic              o_in_stall
);

    bfa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = bfa_pkg::OP_NONE;
        unique case (r_state)
            bfa_pkg::S_CLEAR: begin
                o_op = bfa_pkg::OP_CLEAR;
                if (i_stat.clr_last) n_state = bfa_pkg::S_INIT;
            end
            bfa_pkg::S_INIT: begin
                o_op    = bfa_pkg::OP_INIT;
                n_state = bfa_pkg::S_IDLE;
            end
            bfa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = bfa_pkg::OP_LOAD;
                    n_state = (i_cmd == bfa_pkg::CMD_FREE) ? bfa_pkg::S_F_CHK
                                                           : bfa_pkg::S_A_CHK;
                end
            end
            bfa_pkg::S_A_CHK: begin
                if (i_stat.walk_end_a) begin
                    n_state = bfa_pkg::S_A_FIN;
                end else begin
                    o_op    = bfa_pkg::OP_RD_CUR;
                    n_state = bfa_pkg::S_A_STEP;
                end
            end
            bfa_pkg::S_A_STEP: begin
                o_op    = bfa_pkg::OP_A_STEP;
                n_state = bfa_pkg::S_A_CHK;
            end
            bfa_pkg::S_A_FIN: begin
                o_op    = bfa_pkg::OP_A_FIN;
                n_state = i_stat.found ? bfa_pkg::S_A_WRB : bfa_pkg::S_OUT;
            end
            bfa_pkg::S_A_WRB: begin
                o_op    = bfa_pkg::OP_A_WRB;
                n_state = i_stat.bhead ? bfa_pkg::S_OUT : bfa_pkg::S_A_RDP;
            end
            bfa_pkg::S_A_RDP: begin
                o_op    = bfa_pkg::OP_RD_BPREV;
                n_state = bfa_pkg::S_A_LNK;
            end
            bfa_pkg::S_A_LNK: begin
                o_op    = bfa_pkg::OP_A_LNK;
                n_state = bfa_pkg::S_OUT;
            end
            bfa_pkg::S_F_CHK: begin
                o_op    = bfa_pkg::OP_F_CHK;
                n_state = i_stat.buf_bad ? bfa_pkg::S_OUT : bfa_pkg::S_F_MARK;
            end
            bfa_pkg::S_F_MARK: begin
                o_op    = bfa_pkg::OP_F_MARK;
                n_state = i_stat.mark_bad ? bfa_pkg::S_OUT : bfa_pkg::S_F_WCHK;
            end
            bfa_pkg::S_F_WCHK: begin
                if (i_stat.walk_end_f) begin
                    n_state = bfa_pkg::S_F_PREV;
                end else begin
                    o_op    = bfa_pkg::OP_RD_CUR;
                    n_state = bfa_pkg::S_F_STEP;
                end
            end
            bfa_pkg::S_F_STEP: begin
                o_op    = bfa_pkg::OP_F_STEP;
                n_state = bfa_pkg::S_F_WCHK;
            end
            bfa_pkg::S_F_PREV: begin
                o_op = bfa_pkg::OP_F_PREV;
                if (i_stat.merge_prev) n_state = bfa_pkg::S_OUT;
                else if (i_stat.lhead) n_state = bfa_pkg::S_F_FOL;
                else                   n_state = bfa_pkg::S_F_RDP;
            end
            bfa_pkg::S_F_RDP: begin
                o_op    = bfa_pkg::OP_RD_LPREV;
                n_state = bfa_pkg::S_F_LNK;
            end
            bfa_pkg::S_F_LNK: begin
                o_op    = bfa_pkg::OP_F_LNK;
                n_state = bfa_pkg::S_F_FOL;
            end
            bfa_pkg::S_F_FOL: begin
                o_op    = bfa_pkg::OP_F_FOL;
                n_state = i_stat.merge_fol ? bfa_pkg::S_F_MRG : bfa_pkg::S_OUT;
            end
            bfa_pkg::S_F_MRG: begin
                o_op    = bfa_pkg::OP_F_MRG;
                n_state = bfa_pkg::S_OUT;
            end
            bfa_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_op    = bfa_pkg::OP_OUT;
                    n_state = bfa_pkg::S_IDLE;
                end
            end
            default: n_state = bfa_pkg::S_CLEAR;
        endcase
        if (i_cfg_we) begin
            o_op    = bfa_pkg::OP_NONE;
            n_state = bfa_pkg::S_CLEAR;
        end
    end

    assign o_in_stall = (r_state != bfa_pkg::S_IDLE);

endmodule

// ===== design/bfa_dp.sv =====
module bfa_dp #(
    parameter int ARENA_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfa_pkg::t_op      i_op,
    output bfa_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic [14:0]       i_request_bytes,
    input  logic [15:0]       i_release_offset,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [15:0]       o_data_offset,
    output logic [1:0]        o_status
);

    localparam int AW = (ARENA_BYTES > 1) ? $clog2(ARENA_BYTES) : 1;
    localparam int CW = $clog2(ARENA_BYTES + 1);
    localparam logic [16:0] ARENA_END = 17'(ARENA_BYTES);

    logic [15:0]   r_base, r_len, r_head;
    logic [AW-1:0] r_clr;
    logic [15:0]   r_need, r_buf, r_cur, r_lprev;
    logic [CW-1:0] r_steps;
    logic          r_lhead, r_found, r_bhead, r_rd_ok;
    bfa_pkg::t_hdr r_pdat;
    logic [15:0]   r_boff, r_blen, r_bnext, r_bprev;
    logic [15:0]   r_tnext, r_tlen, r_follow;
    logic [15:0]   r_res_off;
    logic [1:0]    r_res_st;
    logic          r_out_valid;
    logic [15:0]   r_out_off;
    logic [1:0]    r_out_st;

    logic          mem_we;
    logic [15:0]   mem_off;
    bfa_pkg::t_hdr mem_wdata;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [31:0]   ram_q;
    bfa_pkg::t_hdr rd;
    logic          off_ok;
    logic [15:0]   noff;
    logic          split;
    logic          better;

    bfa_ram #(.DEPTH(ARENA_BYTES), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (mem_wdata),
        .o_rdata (ram_q)
    );

    assign rd     = r_rd_ok ? bfa_pkg::t_hdr'(ram_q) : '0;
    assign off_ok = ({1'b0, mem_off} < ARENA_END);
    assign noff   = r_boff + r_need;
    assign split  = ((r_blen - r_need) > bfa_pkg::HEADER_BYTES);
    assign better = (rd.len > r_need) && (!r_found || (rd.len < r_blen));

    always_comb begin
        mem_we    = 1'b0;
        mem_off   = r_cur;
        mem_wdata = '0;
        case (i_op)
            bfa_pkg::OP_CLEAR: mem_we = 1'b1;
            bfa_pkg::OP_INIT: begin
                mem_we    = 1'b1;
                mem_off   = r_base;
                mem_wdata = '{len: r_len, nxt: 16'd0};
            end
            bfa_pkg::OP_A_FIN: begin
                mem_we    = r_found && split;
                mem_off   = noff;
                mem_wdata = '{len: r_blen - r_need, nxt: r_bnext};
            end
            bfa_pkg::OP_A_WRB: begin
                mem_we    = 1'b1;
                mem_off   = r_boff;
                mem_wdata = '{len: r_tlen, nxt: r_boff};
            end
            bfa_pkg::OP_RD_BPREV: mem_off = r_bprev;
            bfa_pkg::OP_A_LNK: begin
                mem_we    = 1'b1;
                mem_off   = r_bprev;
                mem_wdata = '{len: rd.len, nxt: r_tnext};
            end
            bfa_pkg::OP_F_CHK: mem_off = r_buf;
            bfa_pkg::OP_F_PREV: begin
                mem_we = 1'b1;
                if (o_stat.merge_prev) begin
                    mem_off   = r_lprev;
                    mem_wdata = '{len: r_pdat.len + r_blen, nxt: r_pdat.nxt};
                end else begin
                    mem_off   = r_buf;
                    mem_wdata = '{len: r_blen, nxt: r_lhead ? r_head : r_pdat.nxt};
                end
            end
            bfa_pkg::OP_RD_LPREV: mem_off = r_lprev;
            bfa_pkg::OP_F_LNK: begin
                mem_we    = 1'b1;
                mem_off   = r_lprev;
                mem_wdata = '{len: rd.len, nxt: r_buf};
            end
            bfa_pkg::OP_F_FOL: mem_off = r_follow;
            bfa_pkg::OP_F_MRG: begin
                mem_we    = 1'b1;
                mem_off   = r_buf;
                mem_wdata = '{len: r_blen + rd.len, nxt: rd.nxt};
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign ram_addr = (i_op == bfa_pkg::OP_CLEAR) ? r_clr : mem_off[AW-1:0];
    assign ram_we   = mem_we && ((i_op == bfa_pkg::OP_CLEAR) || off_ok);

    always_comb begin
        o_stat.clr_last   = (r_clr == AW'(ARENA_BYTES - 1));
        o_stat.walk_end_a = (r_cur == 16'd0) || (r_steps == CW'(ARENA_BYTES));
        o_stat.walk_end_f = o_stat.walk_end_a || (r_cur > r_buf);
        o_stat.found      = r_found;
        o_stat.bhead      = r_bhead;
        o_stat.lhead      = r_lhead;
        o_stat.buf_bad    = (r_buf == 16'd0) || !({1'b0, r_buf} < ARENA_END);
        o_stat.mark_bad   = (rd.nxt != r_buf);
        o_stat.merge_prev = !r_lhead &&
                            (({1'b0, r_lprev} + {1'b0, r_pdat.len}) == {1'b0, r_buf});
        o_stat.merge_fol  = (r_follow != 16'd0) &&
                            (({1'b0, r_buf} + {1'b0, r_blen}) == {1'b0, r_follow});
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= bfa_pkg::RESET_BASE;
            r_len       <= bfa_pkg::RESET_LENGTH;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bfa_pkg::CFG_ARENA_BASE) r_base <= i_cfg_data;
                else                                        r_len  <= i_cfg_data;
                r_clr <= '0;
            end else if (i_op == bfa_pkg::OP_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_op == bfa_pkg::OP_OUT) r_out_valid <= 1'b1;
            else if (!i_out_stall)       r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= off_ok;
        case (i_op)
            bfa_pkg::OP_INIT: r_head <= r_base;
            bfa_pkg::OP_LOAD: begin
                r_need    <= {1'b0, i_request_bytes} + bfa_pkg::HEADER_BYTES;
                r_buf     <= i_release_offset - bfa_pkg::HEADER_BYTES;
                r_cur     <= r_head;
                r_steps   <= '0;
                r_lhead   <= 1'b1;
                r_lprev   <= 16'd0;
                r_found   <= 1'b0;
                r_bhead   <= 1'b0;
                r_bprev   <= 16'd0;
                r_pdat    <= '0;
                r_res_off <= 16'd0;
                r_res_st  <= bfa_pkg::ST_OK;
            end
            bfa_pkg::OP_A_STEP: begin
                if (better) begin
                    r_found <= 1'b1;
                    r_blen  <= rd.len;
                    r_boff  <= r_cur;
                    r_bnext <= rd.nxt;
                    r_bhead <= r_lhead;
                    r_bprev <= r_lprev;
                end
                r_lhead <= 1'b0;
                r_lprev <= r_cur;
                r_cur   <= rd.nxt;
                r_steps <= r_steps + CW'(1);
            end
            bfa_pkg::OP_A_FIN: begin
                if (!r_found) begin
                    r_res_st <= bfa_pkg::ST_NO_FIT;
                end else begin
                    r_res_off <= r_boff + bfa_pkg::HEADER_BYTES;
                    r_tnext   <= split ? noff : r_bnext;
                    r_tlen    <= split ? r_need : r_blen;
                end
            end
            bfa_pkg::OP_A_WRB: begin
                if (r_bhead) r_head <= r_tnext;
            end
            bfa_pkg::OP_F_CHK: begin
                if (o_stat.buf_bad) r_res_st <= bfa_pkg::ST_BAD_FREE;
            end
            bfa_pkg::OP_F_MARK: begin
                if (o_stat.mark_bad) r_res_st <= bfa_pkg::ST_BAD_FREE;
                r_blen <= rd.len;
            end
            bfa_pkg::OP_F_STEP: begin
                r_lhead <= 1'b0;
                r_lprev <= r_cur;
                r_pdat  <= rd;
                r_cur   <= rd.nxt;
                r_steps <= r_steps + CW'(1);
            end
            bfa_pkg::OP_F_PREV: begin
                r_follow <= r_lhead ? r_head : r_pdat.nxt;
                if (!o_stat.merge_prev && r_lhead) r_head <= r_buf;
            end
            bfa_pkg::OP_OUT: begin
                r_out_off <= r_res_off;
                r_out_st  <= r_res_st;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_offset = r_out_off;
    assign o_status      = r_out_st;

endmodule

// ===== design/best_fit_free_list_allocator_unit.sv =====
// Allocate walks the free list link by link and free walks it up to
// the freed buffer; requests are handled one at a time, with the list
// walk going through the single header memory port.
// Reset and each configuration write start a clearing pass over the
// header memory, with requests stalled until it ends.
module best_fit_free_list_allocator_unit #(
    parameter int ARENA_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [14:0] i_request_bytes,
    input  logic [15:0] i_release_offset,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_data_offset,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    bfa_pkg::t_op      op;
    bfa_pkg::t_dp_stat stat;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_stat     (stat),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    bfa_dp #(.ARENA_BYTES(ARENA_BYTES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_data_offset    (o_data_offset),
        .o_status         (o_status)
    );

endmodule
